// ===== rtl/kphq_pkg.sv =====
// shared types, constants and scaling functions for the knob pickup quantizer
`default_nettype none
package kphq_pkg;

    localparam int KNOB_COUNT  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int KNOB_AW     = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;
    localparam int PICK_SHIFT  = SAMPLE_BITS - 8;
    localparam int PICK_STEP   = 1 << PICK_SHIFT;
    localparam int HYST_BAND   = 1 << (SAMPLE_BITS - 10);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PICKUP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd1;

    localparam logic MODE_DIRECT = 1'b0;
    localparam logic MODE_CATCH  = 1'b1;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    localparam logic [15:0] START_VALUE_RESET = 16'd6553;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample    init_pos;
        logic [7:0] shown;
    } t_pos_entry;

    typedef struct packed {
        t_sample value;
        logic    caught;
    } t_val_entry;

    // 16-bit reading to internal scale
    function automatic t_sample from16(input logic [15:0] x);
        logic [47:0] t;
        t = {8'b0, x, 24'b0};
        t = t >> (40 - SAMPLE_BITS);
        return t[SAMPLE_BITS-1:0];
    endfunction

    // internal scale back to 16 bits
    function automatic logic [15:0] to16(input t_sample v);
        logic [47:0] t;
        t = 48'(v) << 24;
        t = t >> (SAMPLE_BITS + 8);
        return t[15:0];
    endfunction

    function automatic logic [7:0] top8(input t_sample v);
        return v[SAMPLE_BITS-1 -: 8];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kphq_ram.sv =====
// generic single-port-write, registered-read memory
`default_nettype none
module kphq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/kphq_update.sv =====
// per-knob pickup decision and display hysteresis update
`default_nettype none
module kphq_update (
    input  wire logic                   i_op,
    input  wire logic                   i_mode,
    input  wire kphq_pkg::t_sample      i_raw,
    input  wire kphq_pkg::t_pos_entry   i_pos,
    input  wire kphq_pkg::t_val_entry   i_val,
    output kphq_pkg::t_pos_entry        o_pos,
    output kphq_pkg::t_val_entry        o_val
);
    import kphq_pkg::*;

    localparam int CW = SAMPLE_BITS + 2;

    t_sample        diff;
    t_sample        init_pos;
    t_sample        st;
    t_sample        st_n;
    logic           crossed;
    logic           caught_n;
    logic [7:0]     d;
    logic [7:0]     nd;
    logic [9:0]     d10;
    logic [9:0]     nd10;
    logic [CW-1:0]  st_ext;
    logic [CW-1:0]  thr_up;
    logic [CW-1:0]  thr_dn;
    logic [7:0]     shown_n;

    assign init_pos = i_pos.init_pos;
    assign st       = i_val.value;
    assign diff     = (init_pos > i_raw) ? (init_pos - i_raw) : (i_raw - init_pos);

    always_comb begin
        if (i_mode == MODE_DIRECT) begin
            crossed = (SAMPLE_BITS + 1)'(diff) > (SAMPLE_BITS + 1)'(PICK_STEP);
        end else begin
            crossed = ((init_pos > st) && (i_raw < st)) || ((init_pos < st) && (i_raw > st));
        end
    end

    assign caught_n = i_val.caught | crossed;
    assign st_n     = caught_n ? i_raw : st;

    assign d      = i_pos.shown;
    assign nd     = top8(st_n);
    assign d10    = {2'b0, d};
    assign nd10   = {2'b0, nd};
    assign st_ext = CW'(st_n);
    // code boundary plus or minus the hysteresis band
    assign thr_up = ((CW'(d) + CW'(1)) << PICK_SHIFT) + CW'(HYST_BAND);
    assign thr_dn = (CW'(d) << PICK_SHIFT) - CW'(HYST_BAND);

    always_comb begin
        priority if ((nd10 == d10 + 10'd1) && (st_ext > thr_up)) begin
            shown_n = nd;
        end else if (nd10 > d10 + 10'd1) begin
            shown_n = nd;
        end else if ((d10 != 10'd0) && (nd10 == d10 - 10'd1) && (st_ext < thr_dn)) begin
            shown_n = nd;
        end else if (nd10 + 10'd1 < d10) begin
            shown_n = nd;
        end else begin
            shown_n = d;
        end
    end

    always_comb begin
        if (i_op == OP_CAPTURE) begin
            o_pos.init_pos = i_raw;
            o_pos.shown    = top8(i_raw);
            o_val          = i_val;
        end else begin
            o_pos.init_pos = init_pos;
            o_pos.shown    = shown_n;
            o_val.value    = st_n;
            o_val.caught   = caught_n;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/knob_pickup_hysteresis_quantizer.sv =====
// knob pickup quantizer: a request goes through the stage-1 and output registers;
// one request per cycle unless stalled; per-knob state is read from two memories
// and written back from stage 1; a bypass register covers back-to-back hits
// synchronous active-low reset restores the registers and marks every knob
// entry as unwritten, so entries read as their reset values with no clearing pass
`default_nettype none
module knob_pickup_hysteresis_quantizer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_opcode,
    input  wire logic [3:0]                         i_knob,
    input  wire logic [15:0]                        i_raw_value,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [3:0]                              o_knob_out,
    output logic [7:0]                              o_display_value,
    output logic                                    o_is_caught,
    output logic [15:0]                             o_stored_value,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [kphq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [15:0]                        i_cfg_data
);
    import kphq_pkg::*;

    localparam int POS_W = $bits(t_pos_entry);
    localparam int VAL_W = $bits(t_val_entry);

    logic                   r_pickup_mode;
    logic [15:0]            r_start_value;
    logic [KNOB_COUNT-1:0]  r_pos_vld;
    logic [KNOB_COUNT-1:0]  r_val_vld;

    logic                   r_s1_valid;
    logic                   r_s1_op;
    logic [3:0]             r_s1_knob;
    logic                   r_s1_inrange;
    t_sample                r_s1_raw;

    logic                   r_byp_pos_vld;
    logic                   r_byp_val_vld;
    logic [KNOB_AW-1:0]     r_byp_addr;
    t_pos_entry             r_byp_pos;
    t_val_entry             r_byp_val;

    logic                   r_out_valid;
    logic [3:0]             r_out_knob;
    logic [7:0]             r_out_display;
    logic                   r_out_caught;
    logic [15:0]            r_out_stored;

    logic                   n_s1_valid;
    logic                   n_out_valid;

    logic                   accept_in;
    logic                   fire1;
    logic                   we;
    logic                   cfg_we;
    logic                   start_we;
    logic [KNOB_AW-1:0]     s1_addr;
    logic [POS_W-1:0]       ram_pos_q;
    logic [VAL_W-1:0]       ram_val_q;
    t_pos_entry             pos_cur;
    t_val_entry             val_cur;
    t_val_entry             val_reset;
    t_pos_entry             pos_n;
    t_val_entry             val_n;

    assign fire1     = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !fire1;
    assign accept_in = i_valid && !o_stall;
    assign we        = fire1 && r_s1_inrange;
    assign s1_addr   = KNOB_AW'(r_s1_knob);

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign start_we    = cfg_we && (i_cfg_index == REG_START_VALUE);

    kphq_ram #(.WIDTH(POS_W), .DEPTH(KNOB_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (s1_addr),
        .i_wdata (pos_n),
        .i_re    (accept_in),
        .i_raddr (KNOB_AW'(i_knob)),
        .o_rdata (ram_pos_q)
    );

    kphq_ram #(.WIDTH(VAL_W), .DEPTH(KNOB_COUNT)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (s1_addr),
        .i_wdata (val_n),
        .i_re    (accept_in),
        .i_raddr (KNOB_AW'(i_knob)),
        .o_rdata (ram_val_q)
    );

    assign val_reset.value  = from16(r_start_value);
    assign val_reset.caught = 1'b0;

    // newest write wins over the memory, unwritten entries read as reset values
    always_comb begin
        if (r_byp_pos_vld && (r_byp_addr == s1_addr)) begin
            pos_cur = r_byp_pos;
        end else if (r_pos_vld[s1_addr]) begin
            pos_cur = t_pos_entry'(ram_pos_q);
        end else begin
            pos_cur = '0;
        end
        if (r_byp_val_vld && (r_byp_addr == s1_addr)) begin
            val_cur = r_byp_val;
        end else if (r_val_vld[s1_addr]) begin
            val_cur = t_val_entry'(ram_val_q);
        end else begin
            val_cur = val_reset;
        end
    end

    kphq_update u_update (
        .i_op   (r_s1_op),
        .i_mode (r_pickup_mode),
        .i_raw  (r_s1_raw),
        .i_pos  (pos_cur),
        .i_val  (val_cur),
        .o_pos  (pos_n),
        .o_val  (val_n)
    );

    assign n_s1_valid  = accept_in || (r_s1_valid && !fire1);
    assign n_out_valid = fire1 || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pickup_mode <= MODE_CATCH;
            r_start_value <= START_VALUE_RESET;
            r_pos_vld     <= '0;
            r_val_vld     <= '0;
            r_s1_valid    <= 1'b0;
            r_byp_pos_vld <= 1'b0;
            r_byp_val_vld <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (cfg_we && (i_cfg_index == REG_PICKUP_MODE)) begin
                r_pickup_mode <= i_cfg_data[0];
            end
            if (start_we) begin
                r_start_value <= i_cfg_data;
                r_val_vld     <= '0;
                r_byp_val_vld <= 1'b0;
            end else if (we) begin
                r_val_vld[s1_addr] <= 1'b1;
                r_byp_val_vld      <= 1'b1;
            end
            if (we) begin
                r_pos_vld[s1_addr] <= 1'b1;
                r_byp_pos_vld      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_op      <= i_opcode;
            r_s1_knob    <= i_knob;
            r_s1_inrange <= (7'(i_knob) < 7'(KNOB_COUNT));
            r_s1_raw     <= from16(i_raw_value);
        end
        if (we) begin
            r_byp_addr <= s1_addr;
            r_byp_pos  <= pos_n;
            r_byp_val  <= val_n;
        end
        if (fire1) begin
            r_out_knob <= r_s1_knob;
            if (r_s1_inrange) begin
                r_out_display <= pos_n.shown;
                r_out_caught  <= val_n.caught;
                r_out_stored  <= to16(val_n.value);
            end else begin
                r_out_display <= '0;
                r_out_caught  <= 1'b0;
                r_out_stored  <= '0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_knob_out      = r_out_knob;
    assign o_display_value = r_out_display;
    assign o_is_caught     = r_out_caught;
    assign o_stored_value  = r_out_stored;

endmodule
`default_nettype wire
